// ----- hdl/oket_pkg.sv -----
// Shared codes for the ordered key table engine: command modes, result kinds,
// status codes and order flags. No dependencies.
`default_nettype none
package oket_pkg;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_LIST   = 3'd1;
  localparam logic [2:0] MODE_SORTA  = 3'd2;
  localparam logic [2:0] MODE_SORTD  = 3'd3;
  localparam logic [2:0] MODE_SEARCH = 3'd4;
  localparam logic [2:0] MODE_INSERT = 3'd5;
  localparam logic [2:0] MODE_REMOVE = 3'd6;

  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_PROBE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNSORTED = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DUP      = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;
  localparam logic [2:0] ST_ABSENT   = 3'd7;

  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_ASC  = 2'd1;
  localparam logic [1:0] ORD_DESC = 2'd2;

endpackage
`default_nettype wire

// ----- hdl/oket_if.sv -----
// Valid/ready channel interfaces for commands and results.
// No dependencies.
`default_nettype none
interface oket_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] key;
  modport source(output valid, output mode, output key, input ready);
  modport sink(input valid, input mode, input key, output ready);
endinterface

interface oket_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [2:0]         status;
  logic               last;
  modport source(output valid, output kind, output value, output status, output last,
                 input ready);
  modport sink(input valid, input kind, input value, input status, input last,
               output ready);
endinterface
`default_nettype wire

// ----- hdl/oket_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module oket_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ordered_key_table_engine.sv -----
// Ordered key table engine: command sequencer over one key RAM.
// Depends on oket_pkg, oket_if and oket_ram.
//
//  channel | dir | payload                     | accepted when
//  cmd     | in  | mode[2:0], key[31:0]        | cmd.valid && cmd.ready
//  res     | out | kind, value, status, last   | res.valid && res.ready
//
// One command at a time; the RAM read data is registered.
// Load writes the key while idle. List reads and emits each entry. Search emits a
// probe beat per binary-search step. Insert/remove scan the entries; remove then
// shifts the later entries down. Sort is a selection sort on the single read port.
// Reset clears count and order flag; the RAM needs no clearing.
// A stalled result register holds the sequencer until the beat is taken.
`default_nettype none
module ordered_key_table_engine
  import oket_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  oket_in_if.sink   cmd,
  oket_out_if.source res
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DONE = 13'b0000000000010,
    S_LRD  = 13'b0000000000100,
    S_LOUT = 13'b0000000001000,
    S_FRD  = 13'b0000000010000,
    S_FCHK = 13'b0000000100000,
    S_RMRD = 13'b0000001000000,
    S_RMWR = 13'b0000010000000,
    S_SRI  = 13'b0000100000000,
    S_SLI  = 13'b0001000000000,
    S_SRJ  = 13'b0010000000000,
    S_SCJ  = 13'b0100000000000,
    S_SW   = 13'b1000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [1:0]    flag;
  logic [CW-1:0] i, j, best;
  logic signed [31:0] ival, bval, key;
  logic          desc, is_insert, sw_phase, qchk;
  logic signed [CW:0] lo, hi;
  logic [CW-1:0] mid;
  logic [2:0]    st;
  logic signed [31:0] dval;

  logic               ovalid, olast;
  logic [1:0]         okind;
  logic signed [31:0] ovalue;
  logic [2:0]         ostatus;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata_raw;
  logic signed [31:0] rdata;

  logic out_free, acc, full;
  logic signed [CW+1:0] sum;
  logic [CW-1:0] mid_c;
  logic signed [CW:0] lo_n, hi_n;
  logic better;

  assign rdata    = $signed(rdata_raw);
  assign out_free = !ovalid || res.ready;
  assign acc      = cmd.valid && cmd.ready;
  assign full     = (count == CW'(CAPACITY));
  assign cmd.ready = (state == S_IDLE);

  assign res.valid  = ovalid;
  assign res.kind   = okind;
  assign res.value  = ovalue;
  assign res.status = ostatus;
  assign res.last   = olast;

  assign sum   = {lo[CW], lo} + {hi[CW], hi};
  assign mid_c = sum[CW:1];
  assign better = desc ? (rdata > bval) : (rdata < bval);

  always_comb begin
    if ((key < rdata) == (flag == ORD_ASC)) begin
      hi_n = $signed({1'b0, mid}) - (CW+1)'(1);
      lo_n = lo;
    end else begin
      hi_n = hi;
      lo_n = $signed({1'b0, mid}) + (CW+1)'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = cmd.key;
    re    = 1'b0;
    raddr = j[AW-1:0];
    case (state)
      S_IDLE: begin
        if (acc && !full && (cmd.mode == MODE_LOAD ||
            (cmd.mode == MODE_INSERT && count == '0))) begin
          we = 1'b1;
        end
      end
      S_FCHK: begin
        if (rdata != key && j + 1'b1 == count && is_insert) begin
          we    = 1'b1;
          wdata = key;
        end
      end
      S_RMWR: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
      end
      S_SW: begin
        we    = 1'b1;
        waddr = sw_phase ? i[AW-1:0] : best[AW-1:0];
        wdata = sw_phase ? bval : ival;
      end
      S_LRD: begin
        re    = !qchk;
        raddr = qchk ? mid_c[AW-1:0] : j[AW-1:0];
        if (qchk) re = 1'b1;
      end
      S_FRD, S_SRJ: re = 1'b1;
      S_RMRD: begin
        re    = 1'b1;
        raddr = AW'(j + 1'b1);
      end
      S_SRI: begin
        re    = 1'b1;
        raddr = i[AW-1:0];
      end
      default: ;
    endcase
  end

  oket_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      flag   <= ORD_NONE;
      ovalid <= 1'b0;
    end else begin
      if (res.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            key  <= cmd.key;
            dval <= '0;
            st   <= ST_OK;
            j    <= '0;
            i    <= '0;
            qchk <= 1'b0;
            is_insert <= (cmd.mode == MODE_INSERT);
            case (cmd.mode)
              MODE_LOAD: begin
                state <= S_DONE;
                if (full) st <= ST_FULL;
                else begin
                  count <= count + 1'b1;
                  flag  <= ORD_NONE;
                end
              end
              MODE_LIST: begin
                if (count == '0) begin
                  st    <= ST_EMPTY;
                  state <= S_DONE;
                end else state <= S_LRD;
              end
              MODE_SORTA, MODE_SORTD: begin
                desc  <= (cmd.mode == MODE_SORTD);
                flag  <= (cmd.mode == MODE_SORTD) ? ORD_DESC : ORD_ASC;
                state <= (count < CW'(2)) ? S_DONE : S_SRI;
              end
              MODE_SEARCH: begin
                lo <= '0;
                hi <= $signed({1'b0, count}) - (CW+1)'(1);
                if (flag != ORD_ASC && flag != ORD_DESC) begin
                  st    <= ST_UNSORTED;
                  state <= S_DONE;
                end else if (count == '0) begin
                  st    <= ST_NOTFOUND;
                  state <= S_DONE;
                end else begin
                  qchk  <= 1'b1;
                  state <= S_LRD;
                end
              end
              MODE_INSERT: begin
                desc <= (flag == ORD_DESC);
                if (full) begin
                  st    <= ST_FULL;
                  state <= S_DONE;
                end else if (count == '0) begin
                  count <= CW'(1);
                  state <= S_DONE;
                end else state <= S_FRD;
              end
              MODE_REMOVE: begin
                if (count == '0) begin
                  st    <= ST_EMPTY;
                  state <= S_DONE;
                end else state <= S_FRD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            ovalid  <= 1'b1;
            okind   <= KIND_STATUS;
            ovalue  <= dval;
            ostatus <= st;
            olast   <= 1'b1;
            state   <= S_IDLE;
          end
        end
        // list reads entry j; search reads the probe mid
        S_LRD: begin
          if (qchk) mid <= mid_c;
          state <= S_LOUT;
        end
        S_LOUT: begin
          if (out_free) begin
            ovalid  <= 1'b1;
            ostatus <= ST_OK;
            if (qchk) begin
              okind  <= KIND_PROBE;
              ovalue <= 32'(mid);
              olast  <= 1'b0;
              if (rdata == key) begin
                st    <= ST_FOUND;
                dval  <= 32'(mid);
                state <= S_DONE;
              end else begin
                lo <= lo_n;
                hi <= hi_n;
                if (lo_n > hi_n) begin
                  st    <= ST_NOTFOUND;
                  state <= S_DONE;
                end else state <= S_LRD;
              end
            end else begin
              okind  <= KIND_ENTRY;
              ovalue <= rdata;
              olast  <= (j + 1'b1 == count);
              j      <= j + 1'b1;
              state  <= (j + 1'b1 == count) ? S_IDLE : S_LRD;
            end
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rdata == key) begin
            if (is_insert) begin
              st    <= ST_DUP;
              state <= S_DONE;
            end else if (j + 1'b1 < count) begin
              state <= S_RMRD;
            end else begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end else if (j + 1'b1 == count) begin
            if (is_insert) begin
              count <= count + 1'b1;
              state <= (flag == ORD_NONE) ? S_DONE : S_SRI;
            end else begin
              st    <= ST_ABSENT;
              state <= S_DONE;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_FRD;
          end
        end
        S_RMRD: state <= S_RMWR;
        S_RMWR: begin
          j <= j + 1'b1;
          if (j + CW'(2) < count) state <= S_RMRD;
          else begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_SRI: state <= S_SLI;
        S_SLI: begin
          ival  <= rdata;
          bval  <= rdata;
          best  <= i;
          j     <= i + 1'b1;
          state <= S_SRJ;
        end
        S_SRJ: state <= S_SCJ;
        S_SCJ: begin
          if (better) begin
            bval <= rdata;
            best <= j;
          end
          if (j + 1'b1 == count) begin
            sw_phase <= 1'b0;
            state    <= S_SW;
          end else begin
            j     <= j + 1'b1;
            state <= S_SRJ;
          end
        end
        // write the old head to best, then the best key (minimum or maximum) to the head
        S_SW: begin
          sw_phase <= 1'b1;
          if (sw_phase) begin
            i     <= i + 1'b1;
            state <= (i + CW'(2) == count) ? S_DONE : S_SRI;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd.mode != 3'd7) |=> !cmd.ready)
    else $error("command accepted but sequencer stayed idle");

  a_sort_needs_two: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW) |-> (count >= CW'(2)))
    else $error("swap with fewer than two entries");

endmodule
`default_nettype wire

// ----- bench/oket_tb_scoreboard.sv -----
// Command predictor and result checker for the ordered key table engine bench.
// Depends on oket_pkg.
package oket_tb_scoreboard_pkg;
  import oket_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               last;
  } beat_t;

  class key_table_scoreboard;
    int capacity;
    logic signed [31:0] keys[64];
    int count;
    logic [1:0] order;
    beat_t pending[$];
    int errors;

    function new(int cap);
      capacity = cap;
      count = 0;
      order = ORD_NONE;
      errors = 0;
    endfunction

    function void push(logic [1:0] k, logic signed [31:0] v, logic [2:0] s, logic l);
      beat_t b;
      b.kind = k;
      b.value = v;
      b.status = s;
      b.last = l;
      pending.push_back(b);
    endfunction

    function void order_keys(bit desc);
      int best;
      logic signed [31:0] t;
      for (int i = 0; i + 1 < count; i++) begin
        best = i;
        for (int j = i + 1; j < count; j++)
          if (desc ? (keys[j] > keys[best]) : (keys[j] < keys[best])) best = j;
        t = keys[i];
        keys[i] = keys[best];
        keys[best] = t;
      end
    endfunction

    function int locate(logic signed [31:0] key);
      for (int i = 0; i < count; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    // Work out the beats one accepted command produces.
    function void note_command(logic [2:0] mode, logic signed [31:0] key);
      int lo;
      int hi;
      int mid;
      int pos;
      bit hit;
      case (mode)
        MODE_LOAD: begin
          if (count >= capacity) begin
            push(KIND_STATUS, 0, ST_FULL, 1);
          end else begin
            keys[count] = key;
            count++;
            order = ORD_NONE;
            push(KIND_STATUS, 0, ST_OK, 1);
          end
        end
        MODE_LIST: begin
          if (count == 0) push(KIND_STATUS, 0, ST_EMPTY, 1);
          else for (int i = 0; i < count; i++) push(KIND_ENTRY, keys[i], ST_OK, i + 1 == count);
        end
        MODE_SORTA, MODE_SORTD: begin
          order_keys(mode == MODE_SORTD);
          order = (mode == MODE_SORTD) ? ORD_DESC : ORD_ASC;
          push(KIND_STATUS, 0, ST_OK, 1);
        end
        MODE_SEARCH: begin
          if (order == ORD_NONE) begin
            push(KIND_STATUS, 0, ST_UNSORTED, 1);
          end else begin
            lo = 0;
            hi = count - 1;
            hit = 0;
            while (lo <= hi && !hit) begin
              mid = (lo + hi) / 2;
              push(KIND_PROBE, mid, ST_OK, 0);
              if (keys[mid] == key) begin
                push(KIND_STATUS, mid, ST_FOUND, 1);
                hit = 1;
              end else if ((key < keys[mid]) == (order == ORD_ASC)) begin
                hi = mid - 1;
              end else begin
                lo = mid + 1;
              end
            end
            if (!hit) push(KIND_STATUS, 0, ST_NOTFOUND, 1);
          end
        end
        MODE_INSERT: begin
          if (count >= capacity) begin
            push(KIND_STATUS, 0, ST_FULL, 1);
          end else if (locate(key) >= 0) begin
            push(KIND_STATUS, 0, ST_DUP, 1);
          end else begin
            keys[count] = key;
            count++;
            if (order == ORD_ASC) order_keys(0);
            else if (order == ORD_DESC) order_keys(1);
            push(KIND_STATUS, 0, ST_OK, 1);
          end
        end
        MODE_REMOVE: begin
          pos = locate(key);
          if (count == 0) begin
            push(KIND_STATUS, 0, ST_EMPTY, 1);
          end else if (pos < 0) begin
            push(KIND_STATUS, 0, ST_ABSENT, 1);
          end else begin
            for (int i = pos; i + 1 < count; i++) keys[i] = keys[i + 1];
            count--;
            push(KIND_STATUS, 0, ST_OK, 1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what);
      errors++;
      $display("error at %0t: %s", $time, what);
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value %0d, want %0d", got.value, want.value));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endfunction
  endclass
endpackage

// ----- bench/ordered_key_table_engine_tb.sv -----
// Top-level bench for ordered_key_table_engine: directed and random commands,
// checked beat by beat. Depends on oket_pkg, oket_if and oket_tb_scoreboard.
module ordered_key_table_engine_tb;
  import oket_pkg::*;
  import oket_tb_scoreboard_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_off = 0;
  bit   done = 0;

  oket_in_if  cmd();
  oket_out_if res();

  ordered_key_table_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res)
  );

  key_table_scoreboard sb = new(CAPACITY);
  logic signed [31:0] pool[$];

  always #5 clk = ~clk;

  initial begin
    cmd.valid = 0;
    cmd.mode = MODE_LOAD;
    cmd.key = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) sb.check_beat({res.kind, res.value, res.status, res.last});
    res.ready <= !rst && !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Valid stays high after the beat so that back-to-back commands need no gap.
  task automatic send(logic [2:0] mode, logic signed [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 0;
      @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.mode <= mode;
    cmd.key <= key;
    do @(posedge clk); while (!cmd.ready);
    sb.note_command(mode, key);
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (pool.size() > 0 && r < 5) return pool[$urandom_range(pool.size() - 1)];
    if (r == 5) return 32'sh8000_0000;
    if (r == 6) return 32'sh7fff_ffff;
    if (r < 9) return $signed($urandom_range(40)) - 20;
    return $urandom;
  endfunction

  // A mix of table edits, searches and regular sorts, with a rare invalid mode.
  task automatic random_command();
    int r;
    logic signed [31:0] k;
    logic [2:0] m;
    r = $urandom_range(99);
    k = pick_key();
    if (r < 20) m = MODE_LOAD;
    else if (r < 28) m = MODE_LIST;
    else if (r < 35) m = MODE_SORTA;
    else if (r < 42) m = MODE_SORTD;
    else if (r < 70) m = MODE_SEARCH;
    else if (r < 85) m = MODE_INSERT;
    else if (r < 98) m = MODE_REMOVE;
    else m = 3'd7;
    if (m == MODE_LOAD || m == MODE_INSERT) pool.push_back(k);
    send(m, k);
  endtask

  task automatic drain();
    cmd.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty table cases, extremes, both orders, full table.
    send(MODE_LIST, 0);
    send(MODE_SEARCH, 5);
    send(MODE_REMOVE, 5);
    send(MODE_SORTA, 0);
    send(MODE_SEARCH, 5);
    send(MODE_LOAD, 32'sh7fff_ffff);
    send(MODE_LOAD, 32'sh8000_0000);
    send(MODE_LOAD, 32'sh8000_0000);
    send(MODE_SEARCH, 0);
    send(MODE_SORTD, 0);
    send(MODE_SEARCH, 32'sh8000_0000);
    send(MODE_INSERT, -1);
    send(MODE_INSERT, -1);
    send(MODE_LIST, 0);
    send(MODE_SORTA, 0);
    send(MODE_SEARCH, 32'sh7fff_ffff);
    send(MODE_SEARCH, 3);
    send(MODE_REMOVE, 3);
    send(MODE_REMOVE, 32'sh8000_0000);
    send(3'd7, 32'sh5555_aaaa);
    for (int i = 0; i < CAPACITY; i++) send(MODE_INSERT, i * 1000 - 30000);
    send(MODE_LOAD, 1);
    send(MODE_INSERT, 2);
    send(MODE_SEARCH, 1000);
    send(MODE_LIST, 0);
    for (int i = 0; i < CAPACITY; i++) send(MODE_REMOVE, i * 1000 - 30000);
    drain();

    // Random phases with different idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 22 : 0;
      stall_pct = (ph == 2) ? 45 : (ph == 3) ? 22 : 0;
      for (int i = 0; i < 20; i++) random_command();
    end

    // Hold the receiver off while commands keep coming.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) random_command();
    join
    drain();
    done = 1;
  end

  initial begin
    wait (done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/oket_pkg.sv
hdl/oket_if.sv
hdl/oket_ram.sv
hdl/ordered_key_table_engine.sv
bench/oket_tb_scoreboard.sv
bench/ordered_key_table_engine_tb.sv
